@@ hw/rtl/countdown_led_bar_timer_macros.svh @@
// Assertion macros shared by the timer RTL.
`ifndef COUNTDOWN_LED_BAR_TIMER_MACROS_SVH
`define COUNTDOWN_LED_BAR_TIMER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CDT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define CDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/cdt_pkg.sv @@
// Types and constants for the countdown light bar timer.
package cdt_pkg;

   localparam int NUM_LIGHTS_DEF = 30;
   localparam int QUEUE_DEPTH    = 2;
   localparam int IDX_W          = 6;   // light index width at the largest bar
   localparam int CSR_IDX_W      = 1;

   localparam logic [7:0] CFG_RESET     = 8'd50;
   localparam logic [4:0] SET_MIN_RESET = 5'd10;
   localparam logic [5:0] SEC_RELOAD    = 6'd59;
   localparam logic [7:0] MENU_START    = 8'd49;
   localparam logic [7:0] MENU_TOP      = 8'd127;
   localparam logic [7:0] MENU_CAP      = 8'd126;
   localparam logic [7:0] MENU_FLOOR    = 8'd50;
   localparam logic [7:0] MENU_STEP     = 8'd2;

   typedef enum logic [2:0] {
      FUNC_TICK    = 3'd0,
      FUNC_PLUS    = 3'd1,
      FUNC_MINUS   = 3'd2,
      FUNC_START   = 3'd3,
      FUNC_REFRESH = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      MODE_INIT    = 2'd0,
      MODE_MAIN    = 2'd1,
      MODE_COUNT   = 2'd2,
      MODE_EXPIRED = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_INTENSITY = 1'b0,
      CSR_EXPIRED_RED    = 1'b1
   } csr_reg_type;

   // One frame to draw: bar of the last 'count' lights plus an optional marker.
   typedef struct packed {
      mode_type         mode;
      logic [4:0]       count;
      logic [7:0]       bar_r;
      logic [7:0]       bar_g;
      logic [7:0]       bar_b;
      logic             marker_en;
      logic [IDX_W-1:0] marker_idx;
      logic [7:0]       marker_g;
      logic [7:0]       marker_b;
   } frame_type;

endpackage

@@ hw/rtl/cdt_front.sv @@
// Event front end: timer state, configuration and frame descriptors.
module cdt_front import cdt_pkg::*; #(
   parameter int NUM_LIGHTS = NUM_LIGHTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [2:0]           req_func,
   input  logic [4:0]           req_second_phase,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   input  logic                 q_full,
   output logic                 q_push,
   output frame_type            q_frame
);

   localparam int LIMIT = (NUM_LIGHTS < 31) ? NUM_LIGHTS : 31;
   localparam logic [4:0] LIMIT_V = 5'(LIMIT);

   mode_type   mode_ff, mode_in, pend_ff, pend_in;
   logic [4:0] set_min_ff, set_min_in, min_left_ff, min_left_in;
   logic [5:0] sec_left_ff, sec_left_in;
   logic [7:0] menu_ff, menu_in;
   logic [4:0] bounce_ff, bounce_in;
   logic       rising_ff, rising_in;
   logic [7:0] base_ff, red_lvl_ff;

   logic       accept;
   logic [7:0] e_menu, step_menu;
   logic [4:0] e_min, e_bounce;
   logic [5:0] e_sec;
   logic       e_rising;

   assign accept = req_push && !q_full;

   always_comb begin
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      set_min_in  = set_min_ff;
      min_left_in = min_left_ff;
      sec_left_in = sec_left_ff;
      menu_in     = menu_ff;
      bounce_in   = bounce_ff;
      rising_in   = rising_ff;
      q_push      = 1'b0;
      q_frame     = '0;
      e_menu      = menu_ff;
      e_min       = min_left_ff;
      e_sec       = sec_left_ff;
      e_bounce    = bounce_ff;
      e_rising    = rising_ff;
      step_menu   = menu_ff;
      if (accept) begin
         case (req_func)
            FUNC_TICK: begin
               if (mode_ff == MODE_COUNT) begin
                  if (sec_left_ff != '0) begin
                     sec_left_in = sec_left_ff - 6'd1;
                  end else if (min_left_ff != '0) begin
                     min_left_in = min_left_ff - 5'd1;
                     sec_left_in = SEC_RELOAD;
                  end else begin
                     pend_in = MODE_EXPIRED;
                  end
               end
            end
            FUNC_PLUS: begin
               if (mode_ff == MODE_MAIN && set_min_ff < LIMIT_V) begin
                  set_min_in = set_min_ff + 5'd1;
               end
            end
            FUNC_MINUS: begin
               if (mode_ff == MODE_MAIN && set_min_ff != '0) begin
                  set_min_in = set_min_ff - 5'd1;
               end
            end
            FUNC_START: begin
               pend_in = (mode_ff == MODE_MAIN) ? MODE_COUNT : MODE_MAIN;
            end
            FUNC_REFRESH: begin
               // mode entry actions
               if (pend_ff != mode_ff) begin
                  case (pend_ff)
                     MODE_MAIN: e_menu = MENU_START;
                     MODE_COUNT: begin
                        e_min = set_min_ff;
                        e_sec = '0;
                     end
                     MODE_EXPIRED: begin
                        e_bounce = '0;
                        e_rising = 1'b1;
                     end
                     default: ;
                  endcase
               end
               mode_in     = pend_ff;
               menu_in     = e_menu;
               min_left_in = e_min;
               sec_left_in = e_sec;
               bounce_in   = e_bounce;
               rising_in   = e_rising;
               q_frame.mode = pend_ff;
               case (pend_ff)
                  MODE_MAIN: begin
                     if (e_menu[0]) begin
                        step_menu = e_menu + MENU_STEP;
                        if (step_menu > MENU_TOP) step_menu = MENU_CAP;
                     end else begin
                        step_menu = e_menu - MENU_STEP;
                        if (step_menu < MENU_FLOOR) step_menu = MENU_START;
                     end
                     menu_in       = step_menu;
                     q_push        = 1'b1;
                     q_frame.count = set_min_ff;
                     q_frame.bar_g = step_menu;
                  end
                  MODE_COUNT: begin
                     q_push             = 1'b1;
                     q_frame.count      = e_min;
                     q_frame.bar_b      = base_ff;
                     q_frame.marker_en  = 7'(e_min) < 7'(NUM_LIGHTS);
                     q_frame.marker_idx = IDX_W'(NUM_LIGHTS - 1) - IDX_W'(e_min);
                     q_frame.marker_g   = base_ff + 8'(req_second_phase);
                     q_frame.marker_b   = base_ff;
                  end
                  MODE_EXPIRED: begin
                     if (e_rising) begin
                        if (e_bounce < LIMIT_V) bounce_in = e_bounce + 5'd1;
                        if (bounce_in >= LIMIT_V) rising_in = 1'b0;
                     end else begin
                        if (e_bounce != '0) bounce_in = e_bounce - 5'd1;
                        if (bounce_in == '0) rising_in = 1'b1;
                     end
                     q_push        = 1'b1;
                     q_frame.count = bounce_in;
                     q_frame.bar_r = red_lvl_ff;
                  end
                  default: pend_in = MODE_MAIN;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_INIT;
         pend_ff     <= MODE_INIT;
         set_min_ff  <= SET_MIN_RESET;
         min_left_ff <= '0;
         sec_left_ff <= '0;
         menu_ff     <= MENU_START;
         bounce_ff   <= '0;
         rising_ff   <= 1'b1;
         base_ff     <= CFG_RESET;
         red_lvl_ff  <= CFG_RESET;
      end else begin
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         set_min_ff  <= set_min_in;
         min_left_ff <= min_left_in;
         sec_left_ff <= sec_left_in;
         menu_ff     <= menu_in;
         bounce_ff   <= bounce_in;
         rising_ff   <= rising_in;
         if (csr_write) begin
            if (csr_index == CSR_BASE_INTENSITY) base_ff <= csr_data;
            if (csr_index == CSR_EXPIRED_RED) red_lvl_ff <= csr_data;
         end
      end
   end

endmodule

@@ hw/rtl/cdt_queue.sv @@
// Short frame descriptor queue between front end and drawing engine.
`include "countdown_led_bar_timer_macros.svh"
module cdt_queue import cdt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_push,
   input  frame_type q_wdata,
   output logic      q_full,
   input  logic      q_pop,
   output logic      q_empty,
   output frame_type q_rdata
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign q_full  = count_ff == CNT_W'(DEPTH);
   assign q_empty = count_ff == '0;
   assign q_rdata = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wr_ptr_ff] <= q_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         if (q_pop) rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         if (q_push && !q_pop) count_ff <= count_ff + CNT_W'(1);
         else if (q_pop && !q_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   `CDT_ASSERT_NOW(a_no_pop_empty, clock, reset, q_pop, !q_empty, "frame queue popped when empty")
   `CDT_ASSERT_NOW(a_no_push_full, clock, reset, q_push, !q_full, "frame queue pushed when full")
   `CDT_ASSERT_NEXT(a_count_up, clock, reset, q_push && !q_pop, count_ff != '0, "frame queue count lost a push")

endmodule

@@ hw/rtl/cdt_back.sv @@
// Drawing engine: expands one frame descriptor into one word per light.
`include "countdown_led_bar_timer_macros.svh"
module cdt_back import cdt_pkg::*; #(
   parameter int NUM_LIGHTS = NUM_LIGHTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  frame_type  q_rdata,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [4:0] rsp_pixel_index,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [1:0] rsp_mode_now,
   output logic       rsp_last_pixel
);

   localparam int LIGHT_W = $clog2(NUM_LIGHTS);
   localparam logic [LIGHT_W-1:0] LAST_IDX = LIGHT_W'(NUM_LIGHTS - 1);

   logic               busy_ff;
   logic [LIGHT_W-1:0] idx_ff;
   frame_type          frame_ff;
   logic               out_valid_ff;
   logic [4:0]         out_idx_ff;
   logic [7:0]         out_r_ff, out_g_ff, out_b_ff;
   mode_type           out_mode_ff;
   logic               out_last_ff;

   logic       adv, last, lit, on_marker;
   logic [7:0] r_in, g_in, b_in;

   assign adv       = !out_valid_ff || rsp_pop;
   assign last      = idx_ff == LAST_IDX;
   assign q_pop     = !q_empty && (!busy_ff || (adv && last));
   assign lit       = 7'(idx_ff) + 7'(frame_ff.count) >= 7'(NUM_LIGHTS);
   assign on_marker = frame_ff.marker_en && IDX_W'(idx_ff) == frame_ff.marker_idx;

   always_comb begin
      r_in = '0;
      g_in = '0;
      b_in = '0;
      if (on_marker) begin
         g_in = frame_ff.marker_g;
         b_in = frame_ff.marker_b;
      end else if (lit) begin
         r_in = frame_ff.bar_r;
         g_in = frame_ff.bar_g;
         b_in = frame_ff.bar_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) out_valid_ff <= busy_ff;
         if (q_pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff && adv) begin
            if (last) begin
               busy_ff <= 1'b0;
               idx_ff  <= '0;
            end else begin
               idx_ff <= idx_ff + LIGHT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) frame_ff <= q_rdata;
      if (adv && busy_ff) begin
         out_idx_ff  <= 5'(idx_ff);
         out_r_ff    <= r_in;
         out_g_ff    <= g_in;
         out_b_ff    <= b_in;
         out_mode_ff <= frame_ff.mode;
         out_last_ff <= last;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_index = out_idx_ff;
   assign rsp_red         = out_r_ff;
   assign rsp_green       = out_g_ff;
   assign rsp_blue        = out_b_ff;
   assign rsp_mode_now    = out_mode_ff;
   assign rsp_last_pixel  = out_last_ff;

   `CDT_ASSERT_NEXT(a_emit, clock, reset, busy_ff && adv, out_valid_ff, "light word not emitted")
   `CDT_ASSERT_NOW(a_idle_idx, clock, reset, !busy_ff, idx_ff == '0, "light index not parked")
   `CDT_ASSERT_NOW(a_last_pos, clock, reset, out_valid_ff && out_last_ff, out_idx_ff == 5'(LAST_IDX), "frame end flag on wrong light")

endmodule

@@ hw/rtl/countdown_led_bar_timer.sv @@
// Top level of the countdown light bar timer.
// Usage:
//  Events enter on the req_ queue port (push/full): func and second_phase. Ticks,
//  plus, minus and start update the timer state and give no words. A refresh
//  gives one word per light on the rsp_ queue port (empty/pop), lights in order,
//  last_pixel set on the final one; a refresh in init mode gives none.
//  Configuration (csr_write, csr_index, csr_data) sets the countdown blue level
//  and the expired red level; write it while the block is idle.
//  Path: a refresh passes the frame queue, the engine's frame register and the
//  output word register. Throughput: the drawing engine emits one light word
//  per cycle while the receiver does not stall; frames follow each other
//  without a gap. Events are taken one per cycle while the frame queue
//  (QUEUE_DEPTH frames) has room. When the receiver stalls, the output word holds,
//  the engine waits, the frame queue fills and then full rises; every event waits.
//  Reset: synchronous; clears the timer to init mode, 10 set minutes, both
//  levels to 50, and empties the queue and output.
module countdown_led_bar_timer import cdt_pkg::*; #(
   parameter int NUM_LIGHTS = NUM_LIGHTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [2:0]           req_func,
   input  logic [4:0]           req_second_phase,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [4:0]           rsp_pixel_index,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue,
   output logic [1:0]           rsp_mode_now,
   output logic                 rsp_last_pixel,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   logic      q_push, q_pop, q_full, q_empty;
   frame_type q_wdata, q_rdata;

   assign req_full = q_full;

   cdt_front #(.NUM_LIGHTS(NUM_LIGHTS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_func         (req_func),
      .req_second_phase (req_second_phase),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_frame          (q_wdata)
   );

   cdt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_rdata (q_rdata)
   );

   cdt_back #(.NUM_LIGHTS(NUM_LIGHTS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_mode_now    (rsp_mode_now),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
